// ===== design/rme_pkg.sv =====
package rme_pkg;

    // Data path word
    localparam int WORD_WIDTH_DEF = 32;

    // Configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRIVATE_EXP = 2'd2;

    // Reset values, truncated to the word width where they are used
    localparam logic [63:0] MODULUS_RST     = 64'd2;
    localparam logic [63:0] PUBLIC_EXP_RST  = 64'd65537;
    localparam logic [63:0] PRIVATE_EXP_RST = 64'd0;

    // Command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Microcode
    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_WAIT,     // wait for an item, load message and exponent
        OP_RED,      // one bit of message reduction mod modulus
        OP_SETUP,    // base = reduced message, acc = 1
        OP_LD_MUL,   // load multiplier with acc * base
        OP_MUL,      // one step of shift-and-add modular product
        OP_WR_ACC,   // acc = product
        OP_LD_SQR,   // load multiplier with base * base
        OP_WR_BASE,  // base = product, next exponent bit
        OP_DONE,     // write result register
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_CNT_NZ,
        COND_EXP0_ZERO,
        COND_BITS_NZ,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic start;
        logic cnt_nz;
        logic exp0_zero;
        logic bits_nz;
        logic out_busy;
    } t_status;

    // Program addresses
    localparam logic [PC_W-1:0] PC_WAIT    = 4'd0;
    localparam logic [PC_W-1:0] PC_RED     = 4'd1;
    localparam logic [PC_W-1:0] PC_SETUP   = 4'd2;
    localparam logic [PC_W-1:0] PC_LD_MUL  = 4'd3;
    localparam logic [PC_W-1:0] PC_MUL_A   = 4'd4;
    localparam logic [PC_W-1:0] PC_WR_ACC  = 4'd5;
    localparam logic [PC_W-1:0] PC_LD_SQR  = 4'd6;
    localparam logic [PC_W-1:0] PC_MUL_S   = 4'd7;
    localparam logic [PC_W-1:0] PC_WR_BASE = 4'd8;
    localparam logic [PC_W-1:0] PC_DONE    = 4'd9;
    localparam logic [PC_W-1:0] PC_RET     = 4'd10;

    // Branch when cond holds, else fall through to pc + 1
    function automatic t_uword rom_word(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_WAIT:    w = '{op: OP_WAIT,    cond: COND_NO_START,  target: PC_WAIT};
            PC_RED:     w = '{op: OP_RED,     cond: COND_CNT_NZ,    target: PC_RED};
            PC_SETUP:   w = '{op: OP_SETUP,   cond: COND_NEVER,     target: PC_WAIT};
            PC_LD_MUL:  w = '{op: OP_LD_MUL,  cond: COND_EXP0_ZERO, target: PC_LD_SQR};
            PC_MUL_A:   w = '{op: OP_MUL,     cond: COND_CNT_NZ,    target: PC_MUL_A};
            PC_WR_ACC:  w = '{op: OP_WR_ACC,  cond: COND_NEVER,     target: PC_WAIT};
            PC_LD_SQR:  w = '{op: OP_LD_SQR,  cond: COND_NEVER,     target: PC_WAIT};
            PC_MUL_S:   w = '{op: OP_MUL,     cond: COND_CNT_NZ,    target: PC_MUL_S};
            PC_WR_BASE: w = '{op: OP_WR_BASE, cond: COND_BITS_NZ,   target: PC_LD_MUL};
            PC_DONE:    w = '{op: OP_DONE,    cond: COND_OUT_BUSY,  target: PC_DONE};
            PC_RET:     w = '{op: OP_NOP,     cond: COND_ALWAYS,    target: PC_WAIT};
            default:    w = '{op: OP_NOP,     cond: COND_ALWAYS,    target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== design/rme_if.sv =====
interface rme_in_if #(
    parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [WORD_WIDTH-1:0] message;

    modport source (output valid, output command, output message, input ready);
    modport sink   (input valid, input command, input message, output ready);
endinterface

interface rme_out_if #(
    parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

interface rme_cfg_if #(
    parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) ();
    logic                               valid;
    logic                               ready;
    logic [rme_pkg::CFG_INDEX_W-1:0]    index;
    logic [WORD_WIDTH-1:0]              data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/rme_sequencer.sv =====
module rme_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rme_pkg::t_status i_status,
    output rme_pkg::t_uword  o_uword
);

    logic [rme_pkg::PC_W-1:0] r_pc;
    logic [rme_pkg::PC_W-1:0] n_pc;
    rme_pkg::t_uword          uw;
    logic                     taken;

    assign uw      = rme_pkg::rom_word(r_pc);
    assign o_uword = uw;

    always_comb begin
        case (uw.cond)
            rme_pkg::COND_NEVER:     taken = 1'b0;
            rme_pkg::COND_ALWAYS:    taken = 1'b1;
            rme_pkg::COND_NO_START:  taken = !i_status.start;
            rme_pkg::COND_CNT_NZ:    taken = i_status.cnt_nz;
            rme_pkg::COND_EXP0_ZERO: taken = i_status.exp0_zero;
            rme_pkg::COND_BITS_NZ:   taken = i_status.bits_nz;
            rme_pkg::COND_OUT_BUSY:  taken = i_status.out_busy;
            default:                 taken = 1'b1;
        endcase
        n_pc = taken ? uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= rme_pkg::PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // program never runs past its last word
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= rme_pkg::PC_RET)
        else $error("sequencer pc left the program");

    // the wait step is left only when an item starts
    a_wait_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == rme_pkg::PC_WAIT && !i_status.start) |=> r_pc == rme_pkg::PC_WAIT)
        else $error("left wait step without an item");

    // the return step always goes back to waiting
    a_ret_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == rme_pkg::PC_RET) |=> r_pc == rme_pkg::PC_WAIT)
        else $error("return step did not go back to wait");

endmodule

// ===== design/rsa_modular_exponentiation.sv =====
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    command (1b), message (WORD_WIDTH)
// o_out     out  valid/ready    result (WORD_WIDTH)
// i_cfg     in   valid/ready    index (2b: modulus, public exp, private exp), data
//
// One item at a time, with W = WORD_WIDTH. The bit-serial modular multiplier
// does one shift-and-add step per cycle, W steps per product, and up to two
// products per exponent bit.
// Reset (synchronous, active low) loads the register reset values and parks
// the sequencer on its wait step. A stalled result sits in the output register;
// the next item is taken and run meanwhile and waits at its last step.
// Config writes are taken only while the sequencer waits for an item; an
// offered write holds off the input for that cycle.
module rsa_modular_exponentiation #(
    parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rme_in_if.sink      i_in,
    rme_out_if.source   o_out,
    rme_cfg_if.sink     i_cfg
);

    localparam int CNT_W = $clog2(WORD_WIDTH);
    localparam logic [CNT_W-1:0]      CNT_LAST = CNT_W'(WORD_WIDTH - 1);
    localparam logic [WORD_WIDTH-1:0] ONE      = {{(WORD_WIDTH-1){1'b0}}, 1'b1};

    // (a + b) mod m for a, b < m
    function automatic logic [WORD_WIDTH-1:0] add_mod(
        input logic [WORD_WIDTH-1:0] a,
        input logic [WORD_WIDTH-1:0] b,
        input logic [WORD_WIDTH-1:0] m
    );
        logic [WORD_WIDTH:0] s;
        logic [WORD_WIDTH:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, m};
        return (s >= {1'b0, m}) ? d[WORD_WIDTH-1:0] : s[WORD_WIDTH-1:0];
    endfunction

    // configuration
    logic [WORD_WIDTH-1:0] r_modulus,  n_modulus;
    logic [WORD_WIDTH-1:0] r_pub_exp,  n_pub_exp;
    logic [WORD_WIDTH-1:0] r_priv_exp, n_priv_exp;

    // datapath
    logic [WORD_WIDTH-1:0] r_exp,  n_exp;    // exponent, shifted right per bit
    logic [WORD_WIDTH-1:0] r_base, n_base;   // running square of the message
    logic [WORD_WIDTH-1:0] r_acc,  n_acc;    // running product
    logic [WORD_WIDTH-1:0] r_ma,   n_ma;     // multiplicand, doubled each step
    logic [WORD_WIDTH-1:0] r_mb,   n_mb;     // multiplier bits / message bits
    logic [WORD_WIDTH-1:0] r_mp,   n_mp;     // partial product / remainder
    logic [CNT_W-1:0]      r_cnt,  n_cnt;    // inner step count
    logic [CNT_W-1:0]      r_bits, n_bits;   // exponent bit count

    // output register
    logic                  r_out_valid,  n_out_valid;
    logic [WORD_WIDTH-1:0] r_out_result, n_out_result;

    rme_pkg::t_uword  uw;
    rme_pkg::t_status status;

    logic                  in_acc;
    logic                  cfg_acc;
    logic                  out_free;
    logic                  done_wr;
    logic [WORD_WIDTH:0]   red_sum;
    logic [WORD_WIDTH:0]   red_dif;
    logic [WORD_WIDTH-1:0] red_next;

    rme_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uw)
    );

    // a pending config write goes first so an item never sees a half-new key
    assign i_in.ready   = (uw.op == rme_pkg::OP_WAIT) && !i_cfg.valid;
    assign i_cfg.ready  = (uw.op == rme_pkg::OP_WAIT);
    assign in_acc       = i_in.valid && i_in.ready;
    assign cfg_acc      = i_cfg.valid && i_cfg.ready;
    assign out_free     = !r_out_valid || o_out.ready;
    assign done_wr      = (uw.op == rme_pkg::OP_DONE) && out_free;
    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_out_result;

    assign status.start     = in_acc;
    assign status.cnt_nz    = (r_cnt != '0);
    assign status.exp0_zero = !r_exp[0];
    assign status.bits_nz   = (r_bits != '0);
    assign status.out_busy  = !out_free;

    // message reduction, MSB first: r = 2r + bit, minus m if it reached m
    assign red_sum  = {r_mp, r_mb[WORD_WIDTH-1]};
    assign red_dif  = red_sum - {1'b0, r_modulus};
    assign red_next = (red_sum >= {1'b0, r_modulus}) ? red_dif[WORD_WIDTH-1:0]
                                                    : red_sum[WORD_WIDTH-1:0];

    always_comb begin
        n_modulus    = r_modulus;
        n_pub_exp    = r_pub_exp;
        n_priv_exp   = r_priv_exp;
        n_exp        = r_exp;
        n_base       = r_base;
        n_acc        = r_acc;
        n_ma         = r_ma;
        n_mb         = r_mb;
        n_mp         = r_mp;
        n_cnt        = r_cnt;
        n_bits       = r_bits;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_result = r_out_result;

        if (cfg_acc) begin
            case (i_cfg.index)
                rme_pkg::REG_MODULUS:     n_modulus  = i_cfg.data;
                rme_pkg::REG_PUBLIC_EXP:  n_pub_exp  = i_cfg.data;
                rme_pkg::REG_PRIVATE_EXP: n_priv_exp = i_cfg.data;
                default: ;
            endcase
        end

        case (uw.op)
            rme_pkg::OP_WAIT: begin
                if (in_acc) begin
                    n_exp = (i_in.command == rme_pkg::CMD_DECRYPT) ? r_priv_exp : r_pub_exp;
                    n_mb  = i_in.message;
                    n_mp  = '0;
                    n_cnt = CNT_LAST;
                end
            end
            rme_pkg::OP_RED: begin
                n_mp  = red_next;
                n_mb  = {r_mb[WORD_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end
            rme_pkg::OP_SETUP: begin
                n_base = r_mp;
                n_acc  = ONE;
                n_bits = CNT_LAST;
            end
            rme_pkg::OP_LD_MUL: begin
                n_ma  = r_base;
                n_mb  = r_acc;
                n_mp  = '0;
                n_cnt = CNT_LAST;
            end
            rme_pkg::OP_MUL: begin
                if (r_mb[0]) begin
                    n_mp = add_mod(r_mp, r_ma, r_modulus);
                end
                n_ma  = add_mod(r_ma, r_ma, r_modulus);
                n_mb  = {1'b0, r_mb[WORD_WIDTH-1:1]};
                n_cnt = r_cnt - 1'b1;
            end
            rme_pkg::OP_WR_ACC: begin
                n_acc = r_mp;
            end
            rme_pkg::OP_LD_SQR: begin
                n_ma  = r_base;
                n_mb  = r_base;
                n_mp  = '0;
                n_cnt = CNT_LAST;
            end
            rme_pkg::OP_WR_BASE: begin
                n_base = r_mp;
                n_exp  = {1'b0, r_exp[WORD_WIDTH-1:1]};
                n_bits = r_bits - 1'b1;
            end
            rme_pkg::OP_DONE: begin
                if (done_wr) begin
                    n_out_valid  = 1'b1;
                    // modulus 0 or 1 always gives 0
                    n_out_result = (r_modulus <= ONE) ? '0 : r_acc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= rme_pkg::MODULUS_RST[WORD_WIDTH-1:0];
            r_pub_exp   <= rme_pkg::PUBLIC_EXP_RST[WORD_WIDTH-1:0];
            r_priv_exp  <= rme_pkg::PRIVATE_EXP_RST[WORD_WIDTH-1:0];
            r_out_valid <= 1'b0;
        end else begin
            r_modulus   <= n_modulus;
            r_pub_exp   <= n_pub_exp;
            r_priv_exp  <= n_priv_exp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp        <= n_exp;
        r_base       <= n_base;
        r_acc        <= n_acc;
        r_ma         <= n_ma;
        r_mb         <= n_mb;
        r_mp         <= n_mp;
        r_cnt        <= n_cnt;
        r_bits       <= n_bits;
        r_out_result <= n_out_result;
    end

    // an accepted item starts reduction with a full step count
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (uw.op == rme_pkg::OP_RED && r_cnt == CNT_LAST))
        else $error("item accepted without starting reduction");

    // multiplier operands stay reduced
    a_mul_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == rme_pkg::OP_MUL && r_modulus > ONE)
            |-> (r_ma < r_modulus && r_mp < r_modulus))
        else $error("multiplier operand not reduced");

    // base and accumulator are reduced whenever a product is loaded
    a_base_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((uw.op == rme_pkg::OP_LD_MUL || uw.op == rme_pkg::OP_LD_SQR) && r_modulus > ONE)
            |-> (r_base < r_modulus && r_acc < r_modulus))
        else $error("base or accumulator not reduced");

    // a written result lies below the modulus, or is zero
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_wr |=> (r_out_valid && (r_out_result < r_modulus || r_out_result == '0)))
        else $error("result out of range");

endmodule

// ===== test/rme_result_check.sv =====
`timescale 1ns / 100ps

module rme_result_check #(
    parameter int WORD_WIDTH = rme_pkg::WORD_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rme_in_if    in_ch,
    rme_out_if   out_ch,
    rme_cfg_if   cfg_ch,
    output int   o_errors,
    output int   o_pending
);

    typedef logic [WORD_WIDTH-1:0] t_word;

    t_word modulus_q;
    t_word pub_exp_q;
    t_word priv_exp_q;
    t_word power_q[$];
    int    err_count = 0;

    // msg ^ expo mod m, LSB-first square-and-multiply on double-width products
    function automatic t_word mod_power(t_word msg, t_word expo, t_word m);
        logic [2*WORD_WIDTH-1:0] base;
        logic [2*WORD_WIDTH-1:0] acc;
        logic [2*WORD_WIDTH-1:0] wide_m;
        wide_m = m;
        if (m <= 1)
            return '0;
        base = msg % wide_m;
        acc  = 1;
        for (int b = 0; b < WORD_WIDTH; b++) begin
            if (expo[b])
                acc = (acc * base) % wide_m;
            base = (base * base) % wide_m;
        end
        return acc[WORD_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(string what, t_word want, t_word got);
        $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_word expo;
        t_word want;
        if (!i_rst_n) begin
            modulus_q  = rme_pkg::MODULUS_RST[WORD_WIDTH-1:0];
            pub_exp_q  = rme_pkg::PUBLIC_EXP_RST[WORD_WIDTH-1:0];
            priv_exp_q = rme_pkg::PRIVATE_EXP_RST[WORD_WIDTH-1:0];
            power_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    rme_pkg::REG_MODULUS:     modulus_q  = cfg_ch.data;
                    rme_pkg::REG_PUBLIC_EXP:  pub_exp_q  = cfg_ch.data;
                    rme_pkg::REG_PRIVATE_EXP: priv_exp_q = cfg_ch.data;
                    default: ;  // unmapped index, write dropped
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                expo = (in_ch.command == rme_pkg::CMD_DECRYPT) ? priv_exp_q : pub_exp_q;
                power_q.push_back(mod_power(in_ch.message, expo, modulus_q));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (power_q.size() == 0) begin
                    report_mismatch("unexpected result", 'x, out_ch.result);
                end else begin
                    want = power_q.pop_front();
                    if (out_ch.result !== want)
                        report_mismatch("result", want, out_ch.result);
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= power_q.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int W = rme_pkg::WORD_WIDTH_DEF;

    // Items run one at a time; the long receiver hold must cover
    // more than two of them so the output register and the datapath both fill.
    localparam int HOLD_CYCLES     = 6000;
    localparam int DRAIN_CYCLES    = 2400;
    // Cycles without any handshake before giving up. Covers the long hold
    // plus a full worst-case item with margin.
    localparam int STALL_LIMIT     = 30000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int HOLD_PHASE      = 4;
    localparam int QUIET_PHASE     = 2;

    // Index past the register map; writes to it must be dropped
    localparam logic [rme_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic [W-1:0] t_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // Random idling on both sides while set; cleared for quiet stretches
    logic idle_on;
    // Request for the one long receiver hold
    logic hold_req;

    int errors;
    int pending;

    always #10 i_clk = ~i_clk;

    rme_in_if  #(.WORD_WIDTH(W)) in_ch ();
    rme_out_if #(.WORD_WIDTH(W)) out_ch ();
    rme_cfg_if #(.WORD_WIDTH(W)) cfg_ch ();

    rsa_modular_exponentiation #(
        .WORD_WIDTH(W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    rme_result_check #(
        .WORD_WIDTH(W)
    ) u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // ------------------------------------------------------------------
    // Random value shapes. Extremes show up often; plain $urandom covers
    // every bit at both values.
    // ------------------------------------------------------------------
    function automatic t_word rand_modulus();
        case ($urandom_range(0, 9))
            0:       return 2;
            1:       return '1;
            2:       return 1;
            3:       return $urandom_range(2, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_word rand_exponent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 1;
            3:       return $urandom_range(0, 65537);
            default: return $urandom;
        endcase
    endfunction

    // Mostly full-range messages, some reduced below the modulus, some
    // sitting exactly on it
    function automatic t_word rand_message(t_word m);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return (m > 1) ? t_word'($urandom) % m : t_word'($urandom);
            4:       return m;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input channel. valid stays high from one item to the next unless a
    // gap burst is drawn; the caller drops it after the last item.
    // ------------------------------------------------------------------
    task automatic send_item(input logic cmd, input t_word msg);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.message <= msg;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    // Block is idle once every result is back. pending is registered, so
    // step past it before looking, then let the sequencer return to its
    // wait step.
    task automatic wait_idle();
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves cfg valid high; the caller drops it after the last write
    task automatic write_reg(input logic [rme_pkg::CFG_INDEX_W-1:0] idx, input t_word data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    task automatic set_key(input t_word m, input t_word pub_e, input t_word priv_e);
        wait_idle();
        write_reg(rme_pkg::REG_MODULUS, m);
        write_reg(rme_pkg::REG_PUBLIC_EXP, pub_e);
        write_reg(rme_pkg::REG_PRIVATE_EXP, priv_e);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready with random stall bursts, plus one long hold while
    // the sender keeps offering items.
    // ------------------------------------------------------------------
    initial begin : receiver
        bit held;
        int stall;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 3);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake on any channel counts as progress
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_word key_m;
        i_rst_n       <= 1'b0;
        idle_on       <= 1'b1;
        hold_req      <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.command <= rme_pkg::CMD_ENCRYPT;
        in_ch.message <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= rme_pkg::REG_MODULUS;
        cfg_ch.data   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset key: modulus 2, public 65537, private 0 (decrypt gives 1)
        send_item(rme_pkg::CMD_ENCRYPT, '0);
        send_item(rme_pkg::CMD_ENCRYPT, '1);
        send_item(rme_pkg::CMD_DECRYPT, 3);
        in_ch.valid <= 1'b0;

        // Widest modulus and exponent; message equal to and just below it.
        // An unmapped write in between must leave the key alone.
        set_key('1, '1, 1);
        wait_idle();
        write_reg(REG_UNUSED, $urandom);
        cfg_ch.valid <= 1'b0;
        send_item(rme_pkg::CMD_ENCRYPT, '1);
        send_item(rme_pkg::CMD_ENCRYPT, '1 - 1);
        send_item(rme_pkg::CMD_ENCRYPT, '0);
        send_item(rme_pkg::CMD_DECRYPT, 32'h1234_5678);
        send_item(rme_pkg::CMD_DECRYPT, '1);
        send_item(rme_pkg::CMD_ENCRYPT, 1);
        in_ch.valid <= 1'b0;

        // Modulus one, then modulus zero: result is always zero
        set_key(1, $urandom, $urandom);
        send_item(rme_pkg::CMD_ENCRYPT, '1);
        send_item(rme_pkg::CMD_DECRYPT, '0);
        in_ch.valid <= 1'b0;
        set_key(0, $urandom, $urandom);
        send_item(rme_pkg::CMD_ENCRYPT, 5);
        send_item(rme_pkg::CMD_DECRYPT, '1);
        in_ch.valid <= 1'b0;

        // Textbook key pair 61*53: 65 encrypts to 2790 and back
        set_key(3233, 17, 2753);
        send_item(rme_pkg::CMD_ENCRYPT, 65);
        send_item(rme_pkg::CMD_DECRYPT, 2790);
        send_item(rme_pkg::CMD_ENCRYPT, 3233 + 65);
        in_ch.valid <= 1'b0;

        // Smallest legal modulus, zero public exponent
        set_key(2, '0, '1);
        send_item(rme_pkg::CMD_ENCRYPT, 7);
        send_item(rme_pkg::CMD_DECRYPT, 6);
        in_ch.valid <= 1'b0;

        // Random keys. One phase runs with the long output hold; phase 2 and
        // the last two run without any idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            key_m = rand_modulus();
            set_key(key_m, rand_exponent(), rand_exponent());
            idle_on <= (p != QUIET_PHASE) && (p < RANDOM_PHASES - 2);
            if (p == HOLD_PHASE)
                hold_req <= 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(logic'($urandom_range(0, 1)), rand_message(key_m));
            in_ch.valid <= 1'b0;
        end

        // Drain, then watch a while longer for stray results
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/rme_pkg.sv
design/rme_if.sv
design/rme_sequencer.sv
design/rsa_modular_exponentiation.sv
test/rme_result_check.sv
test/testbench.sv
